[rtl/uidc_pkg.sv]
// Shared types, codes and constants of the ISO 14443-A cascade controller.
`default_nettype none
package uidc_pkg;

    localparam int UID_BYTES = 10;
    localparam int UID_W     = UID_BYTES * 8;
    localparam int UID_CNT_W = $clog2(UID_BYTES + 1);

    localparam logic [7:0] SEL_CL1      = 8'h93;
    localparam logic [7:0] SEL_CL2      = 8'h95;
    localparam logic [7:0] SEL_CL3      = 8'h97;
    localparam logic [7:0] CASCADE_TAG  = 8'h88;
    localparam logic [7:0] SAK_CASCADE  = 8'h04;
    localparam logic [3:0] MIN_ANTI_LEN = 4'd5;
    localparam logic [3:0] MIN_SEL_LEN  = 4'd1;
    localparam logic [1:0] LAST_LEVEL   = 2'd2;
    localparam logic [2:0] BYTES_AFTER_CT = 3'd3;
    localparam logic [2:0] BYTES_PLAIN    = 3'd4;
    localparam logic [3:0] MIN_UID_LEN    = 4'd4;
    localparam logic [1:0] LINK_OK        = 2'd0;

    typedef enum logic [1:0] {
        ACT_START      = 2'd0,
        ACT_ANTI_REPLY = 2'd1,
        ACT_SEL_REPLY  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        KIND_ANTICOLL = 3'd0,
        KIND_SELECT   = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_FAILED   = 3'd3,
        KIND_IGNORED  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TIMEOUT    = 3'd1,
        ST_READER_ERR = 3'd2,
        ST_OVERSIZE   = 3'd3,
        ST_SHORT      = 3'd4,
        ST_UID_ERR    = 3'd5
    } t_status;

    typedef struct packed {
        t_action    action;
        logic [1:0] link_code;
        logic [3:0] reply_len;
        logic [7:0] reply_b0;
        logic [7:0] reply_b1;
        logic [7:0] reply_b2;
        logic [7:0] reply_b3;
        logic [7:0] reply_b4;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  sel_code;
        logic [7:0]  cmd_b0;
        logic [7:0]  cmd_b1;
        logic [7:0]  cmd_b2;
        logic [7:0]  cmd_b3;
        logic [7:0]  cmd_b4;
        t_status     status;
        logic [63:0] uid_lo;
        logic [15:0] uid_hi;
        logic [3:0]  uid_len;
        logic [7:0]  sak;
    } t_result;

    function automatic logic [7:0] sel_of(input logic [1:0] level);
        logic [7:0] code;
        unique case (level)
            2'd0:    code = SEL_CL1;
            2'd1:    code = SEL_CL2;
            default: code = SEL_CL3;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

[rtl/uidc_step.sv]
// Cascade state and the combinational step that turns one request into one result.
`default_nettype none
module uidc_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire uidc_pkg::t_item i_item,
    output uidc_pkg::t_result    o_result
);
    import uidc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ANTI = 2'd1,
        PH_SEL  = 2'd2
    } t_phase;

    t_phase               r_phase,     n_phase;
    logic [1:0]           r_level,     n_level;
    logic [31:0]          r_lvl_bytes, n_lvl_bytes;
    logic [UID_W-1:0]     r_store,     n_store;
    logic [UID_CNT_W-1:0] r_count,     n_count;

    t_result              res;
    logic                 ct_first;
    logic [31:0]          app_word;
    logic [UID_CNT_W:0]   app_sum;
    logic [UID_W-1:0]     app_store;
    logic [7:0]           bcc;

    // Bytes of this level that go into the UID: the cascade tag is dropped.
    assign ct_first  = (r_lvl_bytes[7:0] == CASCADE_TAG);
    assign app_word  = ct_first ? {8'h00, r_lvl_bytes[31:8]} : r_lvl_bytes;
    assign app_sum   = {1'b0, r_count}
                     + (UID_CNT_W + 1)'(ct_first ? BYTES_AFTER_CT : BYTES_PLAIN);
    assign app_store = r_store | (UID_W'(app_word) << {r_count, 3'b000});
    assign bcc       = i_item.reply_b0 ^ i_item.reply_b1 ^ i_item.reply_b2
                     ^ i_item.reply_b3;

    always_comb begin
        res         = '0;
        res.kind    = KIND_IGNORED;
        res.status  = ST_OK;
        n_phase     = r_phase;
        n_level     = r_level;
        n_lvl_bytes = r_lvl_bytes;
        n_store     = r_store;
        n_count     = r_count;
        priority if (i_item.action == ACT_START) begin
            n_store      = '0;
            n_count      = '0;
            n_level      = '0;
            n_lvl_bytes  = '0;
            res.kind     = KIND_ANTICOLL;
            res.sel_code = sel_of(2'd0);
            n_phase      = PH_ANTI;
        end else if (i_item.action == ACT_ANTI_REPLY && r_phase == PH_ANTI) begin
            priority if (i_item.link_code != LINK_OK) begin
                res.kind   = KIND_FAILED;
                res.status = t_status'({1'b0, i_item.link_code});
                n_phase    = PH_IDLE;
            end else if (i_item.reply_len < MIN_ANTI_LEN) begin
                res.kind   = KIND_FAILED;
                res.status = ST_SHORT;
                n_phase    = PH_IDLE;
            end else if (bcc != i_item.reply_b4) begin
                res.kind   = KIND_FAILED;
                res.status = ST_UID_ERR;
                n_phase    = PH_IDLE;
            end else begin
                n_lvl_bytes  = {i_item.reply_b3, i_item.reply_b2,
                                i_item.reply_b1, i_item.reply_b0};
                res.kind     = KIND_SELECT;
                res.sel_code = sel_of(r_level);
                res.cmd_b0   = i_item.reply_b0;
                res.cmd_b1   = i_item.reply_b1;
                res.cmd_b2   = i_item.reply_b2;
                res.cmd_b3   = i_item.reply_b3;
                res.cmd_b4   = i_item.reply_b4;
                n_phase      = PH_SEL;
            end
        end else if (i_item.action == ACT_SEL_REPLY && r_phase == PH_SEL) begin
            // After any failure only a start is taken, and a start clears the
            // store, so the store is committed on success paths only.
            priority if (i_item.link_code != LINK_OK) begin
                res.kind   = KIND_FAILED;
                res.status = t_status'({1'b0, i_item.link_code});
                n_phase    = PH_IDLE;
            end else if (i_item.reply_len < MIN_SEL_LEN) begin
                res.kind   = KIND_FAILED;
                res.status = ST_SHORT;
                n_phase    = PH_IDLE;
            end else if (app_sum > (UID_CNT_W + 1)'(UID_BYTES)) begin
                res.kind   = KIND_FAILED;
                res.status = ST_UID_ERR;
                n_phase    = PH_IDLE;
            end else if ((i_item.reply_b0 & SAK_CASCADE) == 8'h00) begin
                if (app_sum < (UID_CNT_W + 1)'(MIN_UID_LEN)) begin
                    res.kind   = KIND_FAILED;
                    res.status = ST_UID_ERR;
                end else begin
                    res.kind    = KIND_DONE;
                    res.uid_lo  = app_store[63:0];
                    res.uid_hi  = app_store[79:64];
                    res.uid_len = app_sum[3:0];
                    res.sak     = i_item.reply_b0;
                    n_store     = app_store;
                    n_count     = app_sum[UID_CNT_W-1:0];
                end
                n_phase = PH_IDLE;
            end else if (r_level == LAST_LEVEL) begin
                res.kind   = KIND_FAILED;
                res.status = ST_UID_ERR;
                n_phase    = PH_IDLE;
            end else begin
                n_level      = r_level + 2'd1;
                n_store      = app_store;
                n_count      = app_sum[UID_CNT_W-1:0];
                res.kind     = KIND_ANTICOLL;
                res.sel_code = sel_of(r_level + 2'd1);
                n_phase      = PH_ANTI;
            end
        end else begin
            res.kind = KIND_IGNORED;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_level     <= '0;
            r_lvl_bytes <= '0;
            r_store     <= '0;
            r_count     <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_lvl_bytes <= n_lvl_bytes;
            r_store     <= n_store;
            r_count     <= n_count;
        end
    end

endmodule
`default_nettype wire

[rtl/uid_cascade_anticollision_top.sv]
// Top level of the ISO 14443-A reader-side anticollision cascade controller.
// A request accepted on the slave side reaches the master side through the input
// register, one step of logic and the result register.
// Throughput: one request per cycle; while a result waits, one more request can
// still enter the empty input register, and only then does the input stall.
// Reset (synchronous, active low) empties both registers and clears the cascade.
`default_nettype none
module uid_cascade_anticollision_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [1:0] link_code, [5:2] reply_len, [13:6] reply_b0, [21:14] reply_b1,
    // [29:22] reply_b2, [37:30] reply_b3, [45:38] reply_b4, [47:46] zero
    input  wire logic [47:0]  s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] sel_code, [15:8] cmd_b0, [23:16] cmd_b1, [31:24] cmd_b2,
    // [39:32] cmd_b3, [47:40] cmd_b4, [50:48] status, [114:51] uid_lo,
    // [130:115] uid_hi, [134:131] uid_len, [142:135] sak, [143] zero
    output logic [143:0]      m_axis_tdata,
    // [2:0] kind
    output logic [2:0]        m_axis_tuser
);
    import uidc_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item, in_item;
    logic    r_out_valid;
    t_result r_out, step_res;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        in_item           = '0;
        in_item.action    = t_action'(s_axis_tuser);
        in_item.link_code = s_axis_tdata[1:0];
        in_item.reply_len = s_axis_tdata[5:2];
        in_item.reply_b0  = s_axis_tdata[13:6];
        in_item.reply_b1  = s_axis_tdata[21:14];
        in_item.reply_b2  = s_axis_tdata[29:22];
        in_item.reply_b3  = s_axis_tdata[37:30];
        in_item.reply_b4  = s_axis_tdata[45:38];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= in_item;
        end
    end

    uidc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {1'b0, r_out.sak, r_out.uid_len, r_out.uid_hi, r_out.uid_lo,
                            r_out.status, r_out.cmd_b4, r_out.cmd_b3, r_out.cmd_b2,
                            r_out.cmd_b1, r_out.cmd_b0, r_out.sel_code};

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_DONE |-> r_out.uid_len >= MIN_UID_LEN)
        else $error("done result with fewer than four UID bytes");

    a_status_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != KIND_FAILED |-> r_out.status == ST_OK)
        else $error("nonzero status on a result that is not a failure");

    a_sel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_ANTICOLL || r_out.kind == KIND_SELECT)
        |-> (r_out.sel_code == SEL_CL1 || r_out.sel_code == SEL_CL2
             || r_out.sel_code == SEL_CL3))
        else $error("command result with a bad select code");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready
        |=> r_in_valid && $stable(r_in_item))
        else $error("pending request lost while the result side stalls");

endmodule
`default_nettype wire
